// ===== design/msvs_pkg.sv =====
// Package for the MessagePack value skip validator.
// Holds nesting limits, marker codes, status codes and shared types.
// No dependencies; the decoder, result queue, status helper and top level import it.
package msvs_pkg;

  localparam int MAX_NEST    = 64;
  localparam int STACK_DEPTH = MAX_NEST + 1;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = 33;

  localparam logic [7:0] MK_POSFIX_MAX = 8'h7f;
  localparam logic [7:0] MK_NEGFIX_MIN = 8'he0;
  localparam logic [7:0] MK_FIXSTR_MASK = 8'he0;
  localparam logic [7:0] MK_FIXSTR_TAG  = 8'ha0;
  localparam logic [7:0] MK_FIXCNT_MASK = 8'hf0;
  localparam logic [7:0] MK_FIXARR_TAG  = 8'h90;
  localparam logic [7:0] MK_FIXMAP_TAG  = 8'h80;

  localparam logic [7:0] MK_NIL      = 8'hc0;
  localparam logic [7:0] MK_RESERVED = 8'hc1;
  localparam logic [7:0] MK_FALSE    = 8'hc2;
  localparam logic [7:0] MK_TRUE     = 8'hc3;
  localparam logic [7:0] MK_BIN8     = 8'hc4;
  localparam logic [7:0] MK_BIN16    = 8'hc5;
  localparam logic [7:0] MK_BIN32    = 8'hc6;
  localparam logic [7:0] MK_EXT8     = 8'hc7;
  localparam logic [7:0] MK_EXT16    = 8'hc8;
  localparam logic [7:0] MK_EXT32    = 8'hc9;
  localparam logic [7:0] MK_FLOAT32  = 8'hca;
  localparam logic [7:0] MK_FLOAT64  = 8'hcb;
  localparam logic [7:0] MK_UINT8    = 8'hcc;
  localparam logic [7:0] MK_UINT16   = 8'hcd;
  localparam logic [7:0] MK_UINT32   = 8'hce;
  localparam logic [7:0] MK_UINT64   = 8'hcf;
  localparam logic [7:0] MK_INT8     = 8'hd0;
  localparam logic [7:0] MK_INT16    = 8'hd1;
  localparam logic [7:0] MK_INT32    = 8'hd2;
  localparam logic [7:0] MK_INT64    = 8'hd3;
  localparam logic [7:0] MK_FIXEXT1  = 8'hd4;
  localparam logic [7:0] MK_FIXEXT2  = 8'hd5;
  localparam logic [7:0] MK_FIXEXT4  = 8'hd6;
  localparam logic [7:0] MK_FIXEXT8  = 8'hd7;
  localparam logic [7:0] MK_FIXEXT16 = 8'hd8;
  localparam logic [7:0] MK_STR8     = 8'hd9;
  localparam logic [7:0] MK_STR16    = 8'hda;
  localparam logic [7:0] MK_STR32    = 8'hdb;
  localparam logic [7:0] MK_ARRAY16  = 8'hdc;
  localparam logic [7:0] MK_ARRAY32  = 8'hdd;
  localparam logic [7:0] MK_MAP16    = 8'hde;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_TRUNC,
    ST_RESERVED,
    ST_DEEP
  } status_t;

  typedef enum logic [1:0] {
    PH_MARKER,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STR,
    KIND_EXT,
    KIND_ARRAY,
    KIND_MAP
  } hdr_kind_t;

  typedef enum logic [2:0] {
    ACT_SCALAR,
    ACT_PAYLOAD,
    ACT_CONTAINER,
    ACT_HEADER,
    ACT_RESERVED
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [4:0] small_len;
    logic [2:0] hdr_bytes;
    hdr_kind_t  hdr_kind;
  } marker_info_t;

endpackage

// ===== design/msvs_in_if.sv =====
// Request channel interface of the MessagePack value skip validator.
// Carries one buffer byte and its end-of-buffer flag; no dependencies.
interface msvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source(output valid, output data_byte, output end_of_buffer, input ready);
  modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== design/msvs_out_if.sv =====
// Result channel interface of the MessagePack value skip validator.
// Carries a status code and the marker of the value concerned; no dependencies.
interface msvs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] value_marker;

  modport source(output valid, output status, output value_marker, input ready);
  modport sink(input valid, input status, input value_marker, output ready);
endinterface

// ===== design/msvs_stack_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the remaining-element counts of open containers; no dependencies.
module msvs_stack_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/msvs_marker_decode.sv =====
// Marker byte classifier for the MessagePack value skip validator.
// Depends on msvs_pkg for marker codes and the marker_info_t type.
module msvs_marker_decode import msvs_pkg::*; (
  input  logic [7:0]   marker,
  output marker_info_t info
);

  always_comb begin
    info = '{action: ACT_SCALAR, small_len: '0, hdr_bytes: '0, hdr_kind: KIND_STR};
    priority if (marker <= MK_POSFIX_MAX || marker >= MK_NEGFIX_MIN) begin
      info.action = ACT_SCALAR;
    end else if ((marker & MK_FIXSTR_MASK) == MK_FIXSTR_TAG) begin
      info.action    = ACT_PAYLOAD;
      info.small_len = marker[4:0];
    end else if ((marker & MK_FIXCNT_MASK) == MK_FIXARR_TAG) begin
      info.action    = ACT_CONTAINER;
      info.small_len = {1'b0, marker[3:0]};
    end else if ((marker & MK_FIXCNT_MASK) == MK_FIXMAP_TAG) begin
      info.action    = ACT_CONTAINER;
      info.small_len = {marker[3:0], 1'b0};
    end else begin
      unique case (marker)
        MK_NIL, MK_FALSE, MK_TRUE: begin
          info.action = ACT_SCALAR;
        end
        MK_RESERVED: begin
          info.action = ACT_RESERVED;
        end
        MK_UINT8, MK_INT8: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd1;
        end
        MK_UINT16, MK_INT16, MK_FIXEXT1: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd2;
        end
        MK_FIXEXT2: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd3;
        end
        MK_UINT32, MK_INT32, MK_FLOAT32: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd4;
        end
        MK_FIXEXT4: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd5;
        end
        MK_UINT64, MK_INT64, MK_FLOAT64: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd8;
        end
        MK_FIXEXT8: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd9;
        end
        MK_FIXEXT16: begin
          info.action = ACT_PAYLOAD; info.small_len = 5'd17;
        end
        MK_STR8, MK_BIN8: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd1; info.hdr_kind = KIND_STR;
        end
        MK_STR16, MK_BIN16: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_STR;
        end
        MK_STR32, MK_BIN32: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_STR;
        end
        MK_EXT8: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd1; info.hdr_kind = KIND_EXT;
        end
        MK_EXT16: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_EXT;
        end
        MK_EXT32: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_EXT;
        end
        MK_ARRAY16: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_ARRAY;
        end
        MK_ARRAY32: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_ARRAY;
        end
        MK_MAP16: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_MAP;
        end
        default: begin
          info.action = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_MAP;
        end
      endcase
    end
  end

endmodule

// ===== design/msvs_out_queue.sv =====
// Two-entry result queue: an output register with a skid register behind it.
// Depends on msvs_pkg for status_t and on msvs_out_if.
module msvs_out_queue import msvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  status_t     push_status,
  input  logic [7:0]  push_marker,
  output logic        full,
  msvs_out_if.source  report
);

  logic       head_valid;
  status_t    head_status;
  logic [7:0] head_marker;
  logic       skid_valid;
  status_t    skid_status;
  logic [7:0] skid_marker;
  logic       drain;

  assign drain = !head_valid || report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        head_valid  <= 1'b1;
        head_status <= skid_status;
        head_marker <= skid_marker;
        skid_valid  <= push;
        skid_status <= push_status;
        skid_marker <= push_marker;
      end else begin
        head_valid  <= push;
        head_status <= push_status;
        head_marker <= push_marker;
      end
    end else if (push) begin
      skid_valid  <= 1'b1;
      skid_status <= push_status;
      skid_marker <= push_marker;
    end
  end

  assign full                = skid_valid;
  assign report.valid        = head_valid;
  assign report.status       = head_status;
  assign report.value_marker = head_marker;

endmodule

// ===== design/msvs_out_queue_unused_guard.sv =====
// Helper that flags a closing walk that ends a top-level value (done) or a buffer (truncated).
// Depends on msvs_pkg for status_t; used by the top level to pick the status.
module msvs_out_queue_unused_guard import msvs_pkg::*; (
  input  logic    emit_done,
  input  logic    last_pending,
  output logic    push,
  output status_t status
);

  assign push   = emit_done || last_pending;
  assign status = emit_done ? ST_DONE : ST_TRUNC;

endmodule

// ===== design/msgpack_value_skip_validator_core.sv =====
// Top level of the MessagePack value skip validator.
// Depends on msvs_pkg, msvs_in_if, msvs_out_if, msvs_stack_ram,
// msvs_marker_decode, msvs_out_queue and msvs_out_queue_unused_guard.
//
// Usage: the buffer channel takes one request per byte of an encoded
// MessagePack buffer, with end_of_buffer set on its last byte. The report
// channel gives one result per complete top-level value (status done), per
// error (reserved marker or nesting deeper than 64) and for a buffer that
// ends inside a value (status truncated), with the first byte of the
// top-level value concerned. After an error the rest of the buffer is
// dropped without results; each buffer end returns the block to its reset
// condition.
// Throughput: one byte per cycle while idle and the result queue has room.
// A byte that closes open containers starts a walk, no byte being taken,
// in which each level visited is a read of the stack RAM followed by a
// check of the count it returns. A result enters the registered queue with
// its byte or at the walk's end. Reset clears the control state; the
// stack RAM needs no clearing. A stalled receiver is absorbed by a two-entry
// result queue; a stall lowers buffer.ready once both entries hold results.
module msgpack_value_skip_validator_core import msvs_pkg::*; (
  input logic        clk,
  input logic        rst,
  msvs_in_if.sink    buffer,
  msvs_out_if.source report
);

  typedef enum logic {S_IDLE, S_CHECK} state_t;

  state_t               state;
  phase_t               phase;
  logic [2:0]           hdr_left;
  hdr_kind_t            hdr_kind;
  logic [31:0]          acc;
  logic [COUNT_W-1:0]   pay_left;
  logic [DEPTH_W-1:0]   depth;
  logic [7:0]           top_marker;
  logic                 last_pending;

  marker_info_t         info;
  logic                 accept;
  logic                 q_full;
  logic [7:0]           b;
  logic                 last;
  logic [31:0]          acc_shift;
  logic [2:0]           hdr_left_dec;
  logic [COUNT_W-1:0]   pay_dec;
  logic                 want_finish;
  logic                 want_open;
  logic                 want_payload;
  logic                 want_fail;
  logic [COUNT_W-1:0]   cmd_val;
  status_t              fail_code;
  logic                 res_finish;
  logic                 res_open;
  logic                 res_payload;
  logic                 res_fail;
  status_t              res_fail_code;
  logic                 go_check;
  logic                 emit_now;
  logic                 trunc_now;
  phase_t               phase_after;
  logic [DEPTH_W-1:0]   depth_after;
  logic [7:0]           marker_now;
  logic [COUNT_W-1:0]   rd_data;
  logic [COUNT_W-1:0]   dec;
  logic                 nonzero;
  logic [DEPTH_W-1:0]   depth_m1;
  logic                 check_emit_done;
  logic                 check_done;
  logic                 check_push;
  status_t              check_status;
  logic                 rd_en;
  logic [DEPTH_W-1:0]   rd_addr;
  logic                 wr_en;
  logic [DEPTH_W-1:0]   wr_addr;
  logic [COUNT_W-1:0]   wr_data;
  logic                 push;
  status_t              push_status;
  logic [7:0]           push_marker;

  assign b            = buffer.data_byte;
  assign last         = buffer.end_of_buffer;
  assign buffer.ready = (state == S_IDLE) && !q_full;
  assign accept       = buffer.valid && buffer.ready;

  msvs_marker_decode u_decode (
    .marker (b),
    .info   (info)
  );

  always_comb begin
    acc_shift    = {acc[23:0], b};
    hdr_left_dec = (hdr_left != 3'd0) ? hdr_left - 3'd1 : 3'd0;
    pay_dec      = pay_left - COUNT_W'(1);
    want_finish  = 1'b0;
    want_open    = 1'b0;
    want_payload = 1'b0;
    want_fail    = 1'b0;
    cmd_val      = '0;
    fail_code    = ST_RESERVED;
    unique case (phase)
      PH_MARKER: begin
        unique case (info.action)
          ACT_SCALAR: want_finish = 1'b1;
          ACT_PAYLOAD: begin
            want_payload = 1'b1;
            cmd_val      = COUNT_W'(info.small_len);
          end
          ACT_CONTAINER: begin
            want_open = 1'b1;
            cmd_val   = COUNT_W'(info.small_len);
          end
          ACT_RESERVED: want_fail = 1'b1;
          default: ;
        endcase
      end
      PH_HEADER: begin
        if (hdr_left_dec == 3'd0) begin
          unique case (hdr_kind)
            KIND_STR: begin
              want_payload = 1'b1;
              cmd_val      = {1'b0, acc_shift};
            end
            KIND_EXT: begin
              want_payload = 1'b1;
              cmd_val      = {1'b0, acc_shift} + COUNT_W'(1);
            end
            KIND_ARRAY: begin
              want_open = 1'b1;
              cmd_val   = {1'b0, acc_shift};
            end
            KIND_MAP: begin
              want_open = 1'b1;
              cmd_val   = {acc_shift, 1'b0};
            end
          endcase
        end
      end
      PH_PAYLOAD: want_finish = (pay_dec == '0);
      PH_DROP: ;
    endcase

    res_finish    = want_finish || ((want_open || want_payload) && cmd_val == '0);
    res_payload   = want_payload && cmd_val != '0;
    res_fail      = want_fail ||
                    (want_open && cmd_val != '0 && depth >= DEPTH_W'(MAX_NEST));
    res_fail_code = want_fail ? fail_code : ST_DEEP;
    res_open      = want_open && cmd_val != '0 && depth < DEPTH_W'(MAX_NEST);

    go_check  = res_finish && depth != '0;
    emit_now  = res_fail || (res_finish && depth == '0);

    priority if (res_fail) begin
      phase_after = PH_DROP;
    end else if (res_finish || res_open) begin
      phase_after = PH_MARKER;
    end else if (res_payload) begin
      phase_after = PH_PAYLOAD;
    end else if (phase == PH_MARKER) begin
      phase_after = PH_HEADER;
    end else begin
      phase_after = phase;
    end
    depth_after = res_open ? depth + DEPTH_W'(1) : depth;

    trunc_now  = last && !go_check && !emit_now && phase_after != PH_DROP &&
                 !(phase_after == PH_MARKER && depth_after == '0);
    marker_now = (phase == PH_MARKER && depth == '0) ? b : top_marker;
  end

  assign dec             = rd_data - COUNT_W'(1);
  assign nonzero         = dec != '0;
  assign depth_m1        = depth - DEPTH_W'(1);
  assign check_emit_done = !nonzero && depth_m1 == '0;
  assign check_done      = nonzero || depth_m1 == '0;

  msvs_out_queue_unused_guard u_close (
    .emit_done    (check_emit_done),
    .last_pending (last_pending),
    .push         (check_push),
    .status       (check_status)
  );

  always_comb begin
    if (state == S_IDLE) begin
      rd_en       = accept && go_check;
      rd_addr     = depth_m1;
      wr_en       = accept && res_open;
      wr_addr     = depth;
      wr_data     = cmd_val;
      push        = accept && (emit_now || trunc_now);
      push_status = emit_now ? (res_fail ? res_fail_code : ST_DONE) : ST_TRUNC;
      push_marker = marker_now;
    end else begin
      rd_en       = !check_done;
      rd_addr     = depth - DEPTH_W'(2);
      wr_en       = nonzero;
      wr_addr     = depth_m1;
      wr_data     = dec;
      push        = check_done && check_push;
      push_status = check_status;
      push_marker = top_marker;
    end
  end

  msvs_stack_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  msvs_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_status (push_status),
    .push_marker (push_marker),
    .full        (q_full),
    .report      (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_MARKER;
      hdr_left     <= '0;
      hdr_kind     <= KIND_STR;
      acc          <= '0;
      pay_left     <= '0;
      depth        <= '0;
      top_marker   <= '0;
      last_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (phase == PH_MARKER && info.action == ACT_HEADER) begin
              hdr_left <= info.hdr_bytes;
              hdr_kind <= info.hdr_kind;
              acc      <= '0;
            end
            if (phase == PH_HEADER) begin
              acc      <= acc_shift;
              hdr_left <= hdr_left_dec;
            end
            if (res_payload) begin
              pay_left <= cmd_val;
            end else if (phase == PH_PAYLOAD) begin
              pay_left <= pay_dec;
            end
            if (go_check) begin
              state        <= S_CHECK;
              last_pending <= last;
              phase        <= phase_after;
              depth        <= depth_after;
            end else if (last) begin
              phase      <= PH_MARKER;
              depth      <= '0;
              top_marker <= '0;
            end else begin
              phase <= phase_after;
              depth <= depth_after;
              if (phase == PH_MARKER && depth == '0) begin
                top_marker <= b;
              end
            end
          end
        end
        S_CHECK: begin
          if (check_done) begin
            state        <= S_IDLE;
            last_pending <= 1'b0;
            if (last_pending) begin
              depth      <= '0;
              top_marker <= '0;
            end else if (!nonzero) begin
              depth <= depth_m1;
            end
          end else begin
            depth <= depth_m1;
          end
        end
      endcase
    end
  end

  a_depth_bounded: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_NEST))
    else $error("open container depth exceeds the nesting limit");

  a_room_during_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> !q_full)
    else $error("result queue full while closing containers");

  a_buffer_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> state == S_CHECK || (depth == '0 && phase == PH_MARKER))
    else $error("state not cleared after the last byte of a buffer");

endmodule

// ===== test/tb_msgpack_value_skip_validator_core.sv =====
`timescale 1ns / 100ps
// Testbench for msgpack_value_skip_validator_core: feeds encoded MessagePack buffers
// and checks every report against a value-end tracker. Depends on msvs_pkg, msvs_in_if,
// msvs_out_if and the core itself.
module tb_msgpack_value_skip_validator_core;
  import msvs_pkg::*;

  localparam int NO_REPORT = -1;
  localparam int ITEM_TARGET = 1950;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [7:0] MK_MAP32 = 8'hdf;

  typedef struct {
    status_t    st;
    logic [7:0] mk;
  } report_t;

  class value_end_tracker;
    phase_t             ph;
    logic [2:0]         hdr_left;
    hdr_kind_t          kind;
    logic [31:0]        acc;
    logic [COUNT_W-1:0] pay_left;
    int unsigned        depth;
    logic [COUNT_W-1:0] counts [STACK_DEPTH];
    logic [7:0]         top;
    report_t            due_reports [$];
    int                 mismatches;
    int                 sent_bytes;

    function new();
      clear();
      mismatches = 0;
      sent_bytes = 0;
    endfunction

    function void clear();
      ph = PH_MARKER;
      hdr_left = '0;
      kind = KIND_STR;
      acc = '0;
      pay_left = '0;
      depth = 0;
      top = '0;
    endfunction

    function int close_value();
      ph = PH_MARKER;
      while (depth > 0) begin
        counts[depth-1] = counts[depth-1] - 1'b1;
        if (counts[depth-1] != 0) return NO_REPORT;
        depth--;
      end
      return ST_DONE;
    endfunction

    function int open_nested(logic [COUNT_W-1:0] n);
      if (n == 0) return close_value();
      if (depth >= MAX_NEST) begin
        ph = PH_DROP;
        return ST_DEEP;
      end
      counts[depth] = n;
      depth++;
      ph = PH_MARKER;
      return NO_REPORT;
    endfunction

    function int begin_payload(logic [COUNT_W-1:0] n);
      if (n == 0) return close_value();
      pay_left = n;
      ph = PH_PAYLOAD;
      return NO_REPORT;
    endfunction

    function int begin_header(logic [2:0] nbytes, hdr_kind_t k);
      hdr_left = nbytes;
      kind = k;
      acc = '0;
      ph = PH_HEADER;
      return NO_REPORT;
    endfunction

    function int on_marker(logic [7:0] m);
      if (depth == 0) top = m;
      if (m <= MK_POSFIX_MAX || m >= MK_NEGFIX_MIN || m == MK_NIL || m == MK_FALSE ||
          m == MK_TRUE)
        return close_value();
      if ((m & MK_FIXSTR_MASK) == MK_FIXSTR_TAG) return begin_payload(m[4:0]);
      if ((m & MK_FIXCNT_MASK) == MK_FIXARR_TAG) return open_nested(m[3:0]);
      if ((m & MK_FIXCNT_MASK) == MK_FIXMAP_TAG) return open_nested({m[3:0], 1'b0});
      case (m)
        MK_RESERVED: begin
          ph = PH_DROP;
          return ST_RESERVED;
        end
        MK_UINT8, MK_INT8: return begin_payload(1);
        MK_UINT16, MK_INT16, MK_FIXEXT1: return begin_payload(2);
        MK_FIXEXT2: return begin_payload(3);
        MK_UINT32, MK_INT32, MK_FLOAT32: return begin_payload(4);
        MK_FIXEXT4: return begin_payload(5);
        MK_UINT64, MK_INT64, MK_FLOAT64: return begin_payload(8);
        MK_FIXEXT8: return begin_payload(9);
        MK_FIXEXT16: return begin_payload(17);
        MK_STR8, MK_BIN8: return begin_header(1, KIND_STR);
        MK_STR16, MK_BIN16: return begin_header(2, KIND_STR);
        MK_STR32, MK_BIN32: return begin_header(4, KIND_STR);
        MK_EXT8: return begin_header(1, KIND_EXT);
        MK_EXT16: return begin_header(2, KIND_EXT);
        MK_EXT32: return begin_header(4, KIND_EXT);
        MK_ARRAY16: return begin_header(2, KIND_ARRAY);
        MK_ARRAY32: return begin_header(4, KIND_ARRAY);
        MK_MAP16: return begin_header(2, KIND_MAP);
        default: return begin_header(4, KIND_MAP);
      endcase
    endfunction

    function int on_header(logic [7:0] b);
      acc = {acc[23:0], b};
      if (hdr_left != 0) hdr_left--;
      if (hdr_left != 0) return NO_REPORT;
      case (kind)
        KIND_STR: return begin_payload({1'b0, acc});
        KIND_EXT: return begin_payload({1'b0, acc} + 33'd1);
        KIND_ARRAY: return open_nested({1'b0, acc});
        default: return open_nested({acc, 1'b0});
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int r;
      report_t e;
      r = NO_REPORT;
      sent_bytes++;
      case (ph)
        PH_MARKER: r = on_marker(b);
        PH_HEADER: r = on_header(b);
        PH_PAYLOAD: begin
          pay_left = pay_left - 1'b1;
          if (pay_left == 0) r = close_value();
        end
        default: ;
      endcase
      if (last && r == NO_REPORT && ph != PH_DROP && !(ph == PH_MARKER && depth == 0))
        r = ST_TRUNC;
      if (r != NO_REPORT) begin
        e.st = status_t'(r);
        e.mk = top;
        due_reports.insert(due_reports.size(), e);
      end
      if (last) clear();
    endfunction

    function void check_report(logic [1:0] st, logic [7:0] mk);
      report_t e;
      if (due_reports.size() == 0) begin
        $error("report with nothing due: status %0d value_marker %02h", st, mk);
        mismatches++;
        return;
      end
      e = due_reports.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        mismatches++;
      end
      if (mk !== e.mk) begin
        $error("value_marker: expected %02h, got %02h", e.mk, mk);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  msvs_in_if  buf_ch ();
  msvs_out_if rep_ch ();

  msgpack_value_skip_validator_core dut (
    .clk(clk),
    .rst(rst),
    .buffer(buf_ch),
    .report(rep_ch)
  );

  value_end_tracker sb = new();
  logic [7:0] frame [$];
  int gen_budget;
  int gen_max_lvl;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 3);
    if (r < 9) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(4, 15);
  endfunction

  function automatic void add_byte(logic [7:0] v);
    frame.insert(frame.size(), v);
  endfunction

  function automatic void push_be(logic [31:0] v, int w);
    for (int i = w - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_rand(int n);
    repeat (n) add_byte(8'($urandom));
  endfunction

  function automatic void emit_value(int lvl);
    int pick;
    int n;
    int w;
    logic [7:0] m;
    if (gen_budget <= 0 || lvl >= gen_max_lvl) pick = $urandom_range(0, 8);
    else pick = $urandom_range(0, 12);
    gen_budget--;
    case (pick)
      0: add_byte(8'($urandom_range(0, MK_POSFIX_MAX)));
      1: add_byte(8'($urandom_range(MK_NEGFIX_MIN, 255)));
      2: case ($urandom_range(0, 2))
        0: add_byte(MK_NIL);
        1: add_byte(MK_FALSE);
        default: add_byte(MK_TRUE);
      endcase
      3: begin
        case ($urandom_range(0, 14))
          0: begin m = MK_UINT8; n = 1; end
          1: begin m = MK_UINT16; n = 2; end
          2: begin m = MK_UINT32; n = 4; end
          3: begin m = MK_UINT64; n = 8; end
          4: begin m = MK_INT8; n = 1; end
          5: begin m = MK_INT16; n = 2; end
          6: begin m = MK_INT32; n = 4; end
          7: begin m = MK_INT64; n = 8; end
          8: begin m = MK_FLOAT32; n = 4; end
          9: begin m = MK_FLOAT64; n = 8; end
          10: begin m = MK_FIXEXT1; n = 2; end
          11: begin m = MK_FIXEXT2; n = 3; end
          12: begin m = MK_FIXEXT4; n = 5; end
          13: begin m = MK_FIXEXT8; n = 9; end
          default: begin m = MK_FIXEXT16; n = 17; end
        endcase
        add_byte(m);
        push_rand(n);
      end
      4: begin
        n = pick_len() % 32;
        add_byte(MK_FIXSTR_TAG | 8'(n));
        push_rand(n);
      end
      5, 6, 7: begin
        n = pick_len();
        case (pick)
          5: begin m = $urandom_range(0, 1) ? MK_STR8 : MK_BIN8; w = 1; end
          6: begin m = $urandom_range(0, 1) ? MK_STR16 : MK_BIN16; w = 2; end
          default: begin m = $urandom_range(0, 1) ? MK_STR32 : MK_BIN32; w = 4; end
        endcase
        add_byte(m);
        push_be(n, w);
        push_rand(n);
      end
      8: begin
        n = pick_len();
        case ($urandom_range(0, 2))
          0: begin m = MK_EXT8; w = 1; end
          1: begin m = MK_EXT16; w = 2; end
          default: begin m = MK_EXT32; w = 4; end
        endcase
        add_byte(m);
        push_be(n, w);
        push_rand(n + 1);
      end
      9: begin
        n = pick_count();
        add_byte(MK_FIXARR_TAG | 8'(n));
        repeat (n) emit_value(lvl + 1);
      end
      10: begin
        n = pick_count();
        add_byte(MK_FIXMAP_TAG | 8'(n));
        repeat (2 * n) emit_value(lvl + 1);
      end
      11: begin
        n = pick_count();
        w = $urandom_range(0, 1) ? 2 : 4;
        add_byte(w == 2 ? MK_ARRAY16 : MK_ARRAY32);
        push_be(n, w);
        repeat (n) emit_value(lvl + 1);
      end
      default: begin
        n = pick_count();
        w = $urandom_range(0, 1) ? 2 : 4;
        add_byte(w == 2 ? MK_MAP16 : MK_MAP32);
        push_be(n, w);
        repeat (2 * n) emit_value(lvl + 1);
      end
    endcase
  endfunction

  function automatic void build_random_frame();
    int pick;
    int n;
    logic [31:0] v;
    frame.delete();
    pick = $urandom_range(0, 99);
    gen_max_lvl = $urandom_range(1, 5);
    gen_budget = $urandom_range(1, 12);
    if (pick < 8) begin
      repeat ($urandom_range(60, 67)) begin
        case ($urandom_range(0, 5))
          0: begin add_byte(MK_ARRAY16); push_be(1, 2); end
          1: begin add_byte(MK_ARRAY32); push_be(1, 4); end
          default: add_byte(MK_FIXARR_TAG | 8'h01);
        endcase
      end
      if ($urandom_range(0, 3) == 0) add_byte(MK_FIXARR_TAG);
      else begin
        gen_budget = 0;
        emit_value(0);
      end
      gen_budget = 2;
      repeat ($urandom_range(0, 2)) emit_value(0);
    end else if (pick < 14) begin
      case ($urandom_range(0, 3))
        0: v = 32'hffffffff;
        1: v = 32'h80000000 | $urandom;
        default: v = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: begin add_byte($urandom_range(0, 1) ? MK_STR32 : MK_BIN32); push_be(v, 4); end
        1: begin add_byte(MK_EXT32); push_be(v, 4); end
        2: begin add_byte(MK_ARRAY32); push_be(v, 4); end
        3: begin add_byte(MK_MAP32); push_be(v, 4); end
        4: begin add_byte(MK_STR16); push_be(v, 2); end
        5: begin add_byte(MK_EXT16); push_be(v, 2); end
        6: begin add_byte(MK_ARRAY16); push_be(v, 2); end
        default: begin add_byte(MK_MAP16); push_be(v, 2); end
      endcase
      push_rand($urandom_range(0, 10));
    end else if (pick < 20) begin
      push_rand($urandom_range(1, 16));
    end else begin
      repeat ($urandom_range(1, 4)) emit_value(0);
      pick = $urandom_range(0, 99);
      if (pick < 15 && frame.size() > 1) begin
        n = $urandom_range(1, frame.size() - 1);
        repeat (n) void'(frame.pop_back());
      end else if (pick < 22) begin
        frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      end else if (pick < 27) begin
        frame[$urandom_range(0, frame.size() - 1)] = MK_RESERVED;
      end
    end
  endfunction

  task automatic send_frame(input bit steady);
    int gap;
    bit last;
    for (int i = 0; i < frame.size(); i++) begin
      gap = steady ? 0 : pick_gap();
      last = (i == frame.size() - 1);
      repeat (gap) begin
        @(negedge clk);
        buf_ch.valid <= 1'b0;
      end
      @(negedge clk);
      buf_ch.valid <= 1'b1;
      buf_ch.data_byte <= frame[i];
      buf_ch.end_of_buffer <= last;
      do @(posedge clk); while (buf_ch.ready !== 1'b1);
      sb.take_byte(frame[i], last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rep_ch.valid === 1'b1 && rep_ch.ready === 1'b1)
      sb.check_report(rep_ch.status, rep_ch.value_marker);
  end

  initial begin
    int stall;
    rep_ch.ready <= 1'b0;
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        rep_ch.ready <= 1'b0;
      end
      repeat ($urandom_range(0, 99) < 10 ? $urandom_range(100, 300) : $urandom_range(1, 12))
      begin
        @(negedge clk);
        rep_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    buf_ch.valid <= 1'b0;
    buf_ch.data_byte <= 8'h00;
    buf_ch.end_of_buffer <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    frame = '{8'h00, MK_POSFIX_MAX, MK_NEGFIX_MIN, 8'hff, MK_NIL, MK_FALSE, MK_TRUE};
    send_frame(1'b0);
    frame = '{MK_FIXARR_TAG, MK_FIXMAP_TAG, MK_FIXSTR_TAG};
    send_frame(1'b0);
    frame = '{MK_BIN8, 8'h00, MK_EXT8, 8'h00, 8'h05};
    send_frame(1'b0);
    frame = '{MK_RESERVED, 8'h00, 8'h01};
    send_frame(1'b0);
    frame = '{MK_STR32, 8'hff};
    send_frame(1'b0);
    frame = '{MK_FIXARR_TAG | 8'h02, 8'h01};
    send_frame(1'b0);
    frame = '{MK_FIXMAP_TAG | 8'h01, MK_NIL, MK_FIXARR_TAG | 8'h01, MK_TRUE};
    send_frame(1'b0);

    while (sb.sent_bytes < ITEM_TARGET) begin
      build_random_frame();
      send_frame($urandom_range(0, 99) < 20);
    end
    @(negedge clk);
    buf_ch.valid <= 1'b0;

    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("msgpack_value_skip_validator_core verification clean");
    end else begin
      $display("msgpack_value_skip_validator_core verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("msgpack_value_skip_validator_core verification failed");
    $finish;
  end

endmodule
